// ===== rtl/ffsa_pkg.sv =====
`timescale 1ns / 1ps
package ffsa_pkg;

    localparam int SLOTS    = 1024;
    localparam int GEN_BITS = 8;
    localparam int IDX_W    = 10;
    localparam int CNT_W    = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic       ACT_ALLOC   = 1'b0;
    localparam logic       ACT_RELEASE = 1'b1;

    localparam logic [1:0] ST_ALLOCATED = 2'd0;
    localparam logic [1:0] ST_RELEASED  = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEANUP_THRES = 1'd1;

    typedef struct packed {
        logic             action;
        logic [IDX_W-1:0] slot_index;
    } t_in_word;

    typedef struct packed {
        logic [1:0]          status;
        logic [IDX_W-1:0]    granted_index;
        logic [GEN_BITS-1:0] generation;
        logic                threshold_crossed;
        logic                free_list_reset;
        logic [CNT_W-1:0]    used_count;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch input word, launch memory reads
        logic exec;   // evaluate, write memories, load result register
    } t_ctrl_cmd;

endpackage

// ===== rtl/ffsa_ctrl.sv =====
`timescale 1ns / 1ps
module ffsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ffsa_pkg::t_ctrl_cmd o_cmd
);
    import ffsa_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic fire;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    // result register is free or being drained this cycle
    assign fire        = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    assign o_cmd.load = i_in_valid && o_in_ready;
    assign o_cmd.exec = fire;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (fire) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        if (fire) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/ffsa_datapath.sv =====
`timescale 1ns / 1ps
module ffsa_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ffsa_pkg::t_ctrl_cmd              i_cmd,
    input  ffsa_pkg::t_in_word               i_in_data,
    input  logic                             i_cfg_we,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ffsa_pkg::CNT_W-1:0]       i_cfg_data,
    output ffsa_pkg::t_out_word              o_out_data
);
    import ffsa_pkg::*;

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
    localparam logic [IDX_W-1:0] NO_SLOT   = '0;

    // {active, generation} per slot; next-link per slot
    logic [GEN_BITS:0]  slot_mem [SLOTS];
    logic [IDX_W-1:0]   link_mem [SLOTS];

    logic [CNT_W-1:0]   r_max_count, r_cleanup_thres;
    logic [IDX_W-1:0]   r_free_head, n_free_head;
    logic [IDX_W-1:0]   r_free_tail, n_free_tail;
    logic [IDX_W-1:0]   r_high_water, n_high_water;
    logic [CNT_W-1:0]   r_in_use, n_in_use;

    logic               r_action;
    logic [IDX_W-1:0]   r_req;
    logic [GEN_BITS:0]  r_slot_rd;
    logic [IDX_W-1:0]   r_link_rd;
    t_out_word          r_out, n_out;

    logic               slot_we;
    logic [IDX_W-1:0]   slot_waddr;
    logic [GEN_BITS:0]  slot_wdata;
    logic               link_we;

    logic               rd_active;
    logic [GEN_BITS-1:0] rd_gen;
    logic [IDX_W-1:0]   rd_addr;

    logic               head_busy, head_pop, can_grow, got, bad_rel;
    logic [IDX_W-1:0]   grant_idx;
    logic [GEN_BITS-1:0] grant_gen;
    logic [CNT_W-1:0]   inc_use;

    assign rd_active = r_slot_rd[GEN_BITS];
    assign rd_gen    = r_slot_rd[GEN_BITS-1:0];
    assign rd_addr   = (i_in_data.action == ACT_RELEASE) ? i_in_data.slot_index : r_free_head;

    // read on accept, write on exec; the two never coincide
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_slot_rd <= slot_mem[rd_addr];
        if (slot_we)    slot_mem[slot_waddr] <= slot_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_link_rd <= link_mem[r_free_head];
        if (link_we)    link_mem[r_free_tail] <= r_req;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_in_data.action;
            r_req    <= i_in_data.slot_index;
        end
        if (i_cmd.exec) r_out <= n_out;
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_free_tail  = r_free_tail;
        n_high_water = r_high_water;
        n_in_use     = r_in_use;
        slot_we      = 1'b0;
        slot_waddr   = r_req;
        slot_wdata   = '0;
        link_we      = 1'b0;
        grant_idx    = NO_SLOT;
        grant_gen    = '0;
        head_busy    = 1'b0;
        head_pop     = 1'b0;
        got          = 1'b0;
        inc_use      = r_in_use + CNT_W'(1);
        can_grow     = ((r_max_count == '0) || (r_in_use < r_max_count)) &&
                       (r_high_water != LAST_SLOT);
        bad_rel      = (r_req == NO_SLOT) || (r_req > r_high_water) || !rd_active;
        n_out        = '0;
        n_out.used_count = r_in_use;

        if (r_action == ACT_ALLOC) begin
            if (r_free_head != NO_SLOT) begin
                if (rd_active) begin
                    // stale list: drop it and fall back to growth
                    head_busy   = 1'b1;
                    n_free_head = NO_SLOT;
                    n_free_tail = NO_SLOT;
                end else begin
                    head_pop    = 1'b1;
                    // a lone entry has no successor link
                    n_free_head = (r_free_head == r_free_tail) ? NO_SLOT : r_link_rd;
                    if (n_free_head == NO_SLOT) n_free_tail = NO_SLOT;
                end
            end
            if (head_pop) begin
                got       = 1'b1;
                grant_idx = r_free_head;
                grant_gen = rd_gen;
            end else if (can_grow) begin
                got          = 1'b1;
                n_high_water = r_high_water + IDX_W'(1);
                grant_idx    = n_high_water;
                grant_gen    = '0;   // fresh slot, never written since reset
            end
            if (got) begin
                n_in_use   = inc_use;
                slot_we    = 1'b1;
                slot_waddr = grant_idx;
                slot_wdata = {1'b1, grant_gen};
                n_out.status            = ST_ALLOCATED;
                n_out.granted_index     = grant_idx;
                n_out.generation        = grant_gen;
                n_out.threshold_crossed = (r_cleanup_thres != '0) &&
                                          (r_cleanup_thres < inc_use);
                n_out.used_count        = inc_use;
            end else begin
                n_out.status = ST_FULL;
            end
            n_out.free_list_reset = head_busy;
        end else begin
            if (bad_rel) begin
                n_out.status = ST_BAD_INDEX;
            end else begin
                if (r_free_head == NO_SLOT) begin
                    n_free_head = r_req;
                end else begin
                    link_we = 1'b1;
                end
                n_free_tail = r_req;
                grant_gen   = rd_gen + GEN_BITS'(1);
                slot_we     = 1'b1;
                slot_waddr  = r_req;
                slot_wdata  = {1'b0, grant_gen};
                if (r_in_use != '0) n_in_use = r_in_use - CNT_W'(1);
                n_out.status        = ST_RELEASED;
                n_out.granted_index = r_req;
                n_out.generation    = grant_gen;
                n_out.used_count    = n_in_use;
            end
        end

        if (!i_cmd.exec) begin
            slot_we      = 1'b0;
            link_we      = 1'b0;
            n_free_head  = r_free_head;
            n_free_tail  = r_free_tail;
            n_high_water = r_high_water;
            n_in_use     = r_in_use;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head     <= NO_SLOT;
            r_free_tail     <= NO_SLOT;
            r_high_water    <= NO_SLOT;
            r_in_use        <= '0;
            r_max_count     <= '0;
            r_cleanup_thres <= '0;
        end else begin
            r_free_head  <= n_free_head;
            r_free_tail  <= n_free_tail;
            r_high_water <= n_high_water;
            r_in_use     <= n_in_use;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MAX_COUNT:     r_max_count     <= i_cfg_data;
                    CFG_CLEANUP_THRES: r_cleanup_thres <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_out_data = r_out;

endmodule

// ===== rtl/fifo_free_list_slot_allocator_top.sv =====
`timescale 1ns / 1ps
// Free-list slot allocator with per-slot generation counters.
// Input channel (i_in_valid / o_in_ready / i_in_data): one word per request,
//   action = allocate or release, slot_index used on release only.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
//   word per request, in request order.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   index 0 max_count, index 1 usage warning level; always ready. Write only
//   while no request is in flight.
// Timing: a request is accepted in the idle state, where the slot and link
//   memories are read; the evaluate state then evaluates, writes the memories
//   back and loads the result register, raising o_out_valid, once the result
//   register is free or draining. Because of the read-then-write, a new request
//   is not taken until the previous one has been evaluated.
// The result register decouples the sides: a new request is taken while a
//   result waits; if the receiver still stalls at evaluation, the block holds
//   in the evaluate state until the register drains.
// Reset: synchronous, active low. Free list empty, high-water and used count
//   zero, config zero. Slot memory needs no clearing pass: slots above the
//   high-water mark are treated as never used and get generation 0 on first
//   allocation, so the block is ready the cycle after reset.
module fifo_free_list_slot_allocator_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ffsa_pkg::t_in_word             i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ffsa_pkg::t_out_word            o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffsa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffsa_pkg::CNT_W-1:0]     i_cfg_data
);
    import ffsa_pkg::*;

    t_ctrl_cmd cmd;

    // config registers live in the datapath and take a write every cycle
    assign o_cfg_ready = 1'b1;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    ffsa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
